### hdl/closed_cardinal_spline_interpolator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the closed cardinal spline interpolator
// Each macro expands to one labelled concurrent assertion on clk, which is
// switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CLOSED_CARDINAL_SPLINE_INTERPOLATOR_CORE_MACROS_SVH
`define CLOSED_CARDINAL_SPLINE_INTERPOLATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCSI_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCSI_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ccsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsi_pkg
// Types and constants shared by the spline interpolator core and its
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
package ccsi_pkg;

	localparam int COORD_W    = 16;
	localparam int WGT_W      = 18;
	localparam int MOP_W      = 34;
	localparam int PROD_W     = WGT_W + MOP_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int SEG_W      = 11;
	localparam int STEP_W     = 4;
	localparam int SUB_W      = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int ROUND_SHIFT = 31;
	localparam int PROD_SHIFT  = 15;
	localparam int RESULT_LIMIT = 48;

	localparam logic [CFG_IDX_W-1:0] REG_TENSION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBDIV  = 1'd1;
	localparam logic [SUB_W-1:0]     SUBDIV_RESET = 5'd4;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      last_point;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] curve_x;
		logic signed [COORD_W-1:0] curve_y;
		logic [SEG_W-1:0]          segment_index;
		logic [STEP_W-1:0]         step_index;
		logic                      last_result;
	} curve_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} xy_t;

	// Hermite weights of one step, Q1.16.
	typedef struct packed {
		logic signed [WGT_W-1:0] h00;
		logic signed [WGT_W-1:0] h10;
		logic signed [WGT_W-1:0] h01;
		logic signed [WGT_W-1:0] h11;
	} basis_t;

	typedef struct packed {
		logic       valid;
		logic       mwrite;
		logic [1:0] mdst;
		logic       clear;
		logic       shift;
		logic       fin;
		logic       coord_y;
	} mac_ctl_t;

	typedef struct packed {
		logic                      m_valid;
		logic [1:0]                mdst;
		logic signed [MOP_W-1:0]   m;
		logic                      res_valid;
		logic                      res_y;
		logic signed [COORD_W-1:0] res;
	} mac_sts_t;

endpackage

### hdl/closed_cardinal_spline_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closed_cardinal_spline_interpolator_core
// Closed cardinal spline: control points in, Hermite-blended curve points out.
// ----------------------------------------------------------------------------
// Usage. Control points arrive on the point channel (valid/stall) and the
// final point of a curve carries last_point. Curve points leave on the curve
// channel (valid/stall), each tagged with its segment and step, and the final
// result caused by an item carries last_result. Tension and subdivisions are
// written through the cfg port while the block is idle.
// The block takes one item at a time: point_stall stays high until every
// result of the current item has been loaded into the output register.
// Points 0 to 2 of a curve that are not last produce nothing. Later points
// produce one segment; the last point closes up to four segments (at most
// 48 results). A segment loads its control points and forms 4 tangent
// products; then the start point is output directly, while a blended
// point takes eight products through the single 18 x 34 bit multiplier
// plus its three-stage drain. When the receiver stalls, the finished
// item waits in the output register and the sequencer holds before
// loading the next one. Reset empties the output, clears the point count
// and restores tension 0, subdivisions 4.
// ----------------------------------------------------------------------------
module closed_cardinal_spline_interpolator_core #(
	parameter int MAX_POINTS       = 2048,
	parameter int MAX_SUBDIVISIONS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                point_valid,
	output logic                                point_stall,
	input  ccsi_pkg::point_t                    point,
	output logic                                curve_valid,
	input  logic                                curve_stall,
	output ccsi_pkg::curve_t                    curve,
	input  logic                                cfg_write,
	input  logic [ccsi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ccsi_pkg::CFG_DATA_W-1:0]     cfg_data
);

	`include "closed_cardinal_spline_interpolator_core_macros.svh"

	localparam int CW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int IW  = CW + 2;
	localparam int SIW = (MAX_SUBDIVISIONS > 1) ? $clog2(MAX_SUBDIVISIONS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEG  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_WAIT = 3'd5;

	// Segment kinds, in the order they are emitted.
	localparam logic [2:0] SK_RUN    = 3'd0;
	localparam logic [2:0] SK_WRAP_A = 3'd1;
	localparam logic [2:0] SK_WRAP_B = 3'd2;
	localparam logic [2:0] SK_CLOSE  = 3'd3;
	localparam logic [2:0] SK_PAIR_A = 3'd4;
	localparam logic [2:0] SK_PAIR_B = 3'd5;
	localparam logic [2:0] SK_SINGLE = 3'd6;

	localparam logic [3:0] PH_PREP_END = 4'd3;
	localparam logic [3:0] PH_MUL_END  = 4'd8;

	logic [2:0]                             state_q;
	logic [3:0]                             ph_q;
	logic [CW-1:0]                          count_q;
	logic [CW-1:0]                          base_q;
	logic [2:0]                             k_q;
	logic [2:0]                             k_end_q;
	logic [SIW-1:0]                         s_m1_q;
	logic [SIW-1:0]                         i_q;
	ccsi_pkg::xy_t                          old0_q, r0_q, r1_q, r2_q, f0_q, f1_q, th_q;
	ccsi_pkg::xy_t                          seg_a_q, seg_b_q, seg_c_q, seg_d_q;
	logic [ccsi_pkg::SEG_W-1:0]             segidx_q;
	logic signed [ccsi_pkg::MOP_W-1:0]      m_q [4];
	ccsi_pkg::basis_t                       w_q;
	logic signed [ccsi_pkg::COORD_W-1:0]    rx_q, ry_q;
	logic signed [ccsi_pkg::CFG_DATA_W-1:0] tension_q;
	logic [ccsi_pkg::SUB_W-1:0]             subdiv_q;
	logic                                   curve_valid_q;
	ccsi_pkg::curve_t                       curve_q;

	ccsi_pkg::basis_t                       basis_w [MAX_SUBDIVISIONS][MAX_SUBDIVISIONS];

	logic                                   accept;
	logic                                   is_last;
	logic [IW-1:0]                          idx_w;
	logic [ccsi_pkg::SUB_W-1:0]             s_eff;
	logic [2:0]                             k_start, k_stop;
	ccsi_pkg::xy_t                          sel_a, sel_b, sel_c, sel_d, cur;
	logic [ccsi_pkg::SEG_W-1:0]             sel_idx;
	logic [ccsi_pkg::SEG_W-1:0]             base11;
	logic                                   out_load;
	logic                                   seg_done;
	logic [2:0]                             j;
	logic signed [ccsi_pkg::WGT_W-1:0]      tfq;
	logic signed [ccsi_pkg::COORD_W:0]      diff;
	logic signed [ccsi_pkg::WGT_W-1:0]      op_a;
	logic signed [ccsi_pkg::MOP_W-1:0]      op_b;
	ccsi_pkg::mac_ctl_t                     mctl;
	ccsi_pkg::mac_sts_t                     msts;

	// Hermite weights for every subdivision count and step, worked out at
	// elaboration and rounded half away from zero to Q1.16.
	for (genvar gs = 1; gs <= MAX_SUBDIVISIONS; gs++) begin : g_basis_s
		for (genvar gi = 0; gi < MAX_SUBDIVISIONS; gi++) begin : g_basis_i
			if (gi < gs) begin : g_used
				localparam int S3  = gs * gs * gs;
				localparam int N00 = 2 * gi * gi * gi - 3 * gi * gi * gs + S3;
				localparam int N10 = gi * (gs - gi) * (gs - gi);
				localparam int N01 = 3 * gi * gi * gs - 2 * gi * gi * gi;
				localparam int N11 = gi * gi * gs - gi * gi * gi;
				localparam int H00 = (2 * N00 * 65536 + S3) / (2 * S3);
				localparam int H10 = (2 * N10 * 65536 + S3) / (2 * S3);
				localparam int H01 = (2 * N01 * 65536 + S3) / (2 * S3);
				localparam int H11 = -((2 * N11 * 65536 + S3) / (2 * S3));
				assign basis_w[gs-1][gi] = '{h00: ccsi_pkg::WGT_W'(H00),
					h10: ccsi_pkg::WGT_W'(H10), h01: ccsi_pkg::WGT_W'(H01),
					h11: ccsi_pkg::WGT_W'(H11)};
			end else begin : g_unused
				assign basis_w[gs-1][gi] = '0;
			end
		end
	end

	assign point_stall = (state_q != ST_IDLE);
	assign accept      = point_valid && (state_q == ST_IDLE);
	assign idx_w       = IW'(count_q);
	assign is_last     = point.last_point || (count_q == CW'(MAX_POINTS - 1));
	assign cur         = '{x: point.point_x, y: point.point_y};

	// Effective subdivisions and the run of segments this item closes.
	always_comb begin
		if (subdiv_q == '0) begin
			s_eff = ccsi_pkg::SUB_W'(1);
		end else if (subdiv_q > ccsi_pkg::SUB_W'(MAX_SUBDIVISIONS)) begin
			s_eff = ccsi_pkg::SUB_W'(MAX_SUBDIVISIONS);
		end else begin
			s_eff = subdiv_q;
		end
		k_start = SK_RUN;
		k_stop  = SK_RUN;
		if (is_last) begin
			if (idx_w == IW'(0)) begin
				k_start = SK_SINGLE;
				k_stop  = SK_SINGLE;
				s_eff   = ccsi_pkg::SUB_W'(1);
			end else if (idx_w == IW'(1)) begin
				k_start = SK_PAIR_A;
				k_stop  = SK_PAIR_B;
			end else if (idx_w == IW'(2)) begin
				k_start = SK_WRAP_A;
				k_stop  = SK_CLOSE;
			end else begin
				k_start = SK_RUN;
				k_stop  = SK_CLOSE;
				// Four closing segments must fit the result limit.
				if (s_eff > ccsi_pkg::SUB_W'(ccsi_pkg::RESULT_LIMIT / 4)) begin
					s_eff = ccsi_pkg::SUB_W'(ccsi_pkg::RESULT_LIMIT / 4);
				end
			end
		end
	end

	// Control points of the current segment kind.
	assign base11 = ccsi_pkg::SEG_W'(base_q);

	always_comb begin
		sel_a   = r2_q;
		sel_b   = r2_q;
		sel_c   = r2_q;
		sel_d   = r2_q;
		sel_idx = '0;
		case (k_q)
			SK_RUN: begin
				sel_a = old0_q; sel_b = r0_q; sel_c = r1_q; sel_d = r2_q;
				sel_idx = base11 - ccsi_pkg::SEG_W'(2);
			end
			SK_WRAP_A: begin
				sel_a = r0_q; sel_b = r1_q; sel_c = r2_q; sel_d = f0_q;
				sel_idx = base11 - ccsi_pkg::SEG_W'(1);
			end
			SK_WRAP_B: begin
				sel_a = r1_q; sel_b = r2_q; sel_c = f0_q; sel_d = f1_q;
				sel_idx = base11;
			end
			SK_CLOSE: begin
				sel_a = r2_q; sel_b = f0_q; sel_c = f1_q; sel_d = th_q;
			end
			SK_PAIR_A: begin
				sel_a = f1_q; sel_b = f0_q; sel_c = f1_q; sel_d = f0_q;
			end
			SK_PAIR_B: begin
				sel_a = f0_q; sel_b = f1_q; sel_c = f0_q; sel_d = f1_q;
				sel_idx = ccsi_pkg::SEG_W'(1);
			end
			default: begin
				sel_idx = '0;
			end
		endcase
	end

	// Operand selection for the shared multiplier. The tangent setup forms
	// tf * (c - a) and tf * (d - b) for x and then y; a blended point then
	// accumulates four weighted terms for x and four for y.
	assign tfq = ccsi_pkg::WGT_W'(16384) - ccsi_pkg::WGT_W'(tension_q);
	assign j   = 3'(ph_q - 4'd1);

	always_comb begin
		mctl = '0;
		op_a = tfq;
		op_b = '0;
		diff = '0;
		if (state_q == ST_PREP) begin
			if (ph_q[0]) begin
				diff = ph_q[1] ? (17'(seg_d_q.y) - 17'(seg_b_q.y))
					: (17'(seg_d_q.x) - 17'(seg_b_q.x));
			end else begin
				diff = ph_q[1] ? (17'(seg_c_q.y) - 17'(seg_a_q.y))
					: (17'(seg_c_q.x) - 17'(seg_a_q.x));
			end
			op_b        = ccsi_pkg::MOP_W'(diff);
			mctl.valid  = 1'b1;
			mctl.mwrite = 1'b1;
			mctl.mdst   = ph_q[1:0];
		end else if (state_q == ST_MUL && ph_q != 4'd0) begin
			mctl.valid   = 1'b1;
			mctl.coord_y = j[2];
			mctl.clear   = (j[1:0] == 2'd0);
			mctl.shift   = !j[1];
			mctl.fin     = (j[1:0] == 2'd3);
			case (j[1:0])
				2'd0: begin
					op_a = w_q.h00;
					op_b = ccsi_pkg::MOP_W'(j[2] ? seg_b_q.y : seg_b_q.x);
				end
				2'd1: begin
					op_a = w_q.h01;
					op_b = ccsi_pkg::MOP_W'(j[2] ? seg_c_q.y : seg_c_q.x);
				end
				2'd2: begin
					op_a = w_q.h10;
					op_b = m_q[{j[2], 1'b0}];
				end
				default: begin
					op_a = w_q.h11;
					op_b = m_q[{j[2], 1'b1}];
				end
			endcase
		end
	end

	ccsi_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op_a   (op_a),
		.op_b   (op_b),
		.ctl    (mctl),
		.sts    (msts)
	);

	assign out_load = (state_q == ST_EMIT) && (!curve_valid_q || !curve_stall);
	assign seg_done = (i_q == s_m1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tension_q <= '0;
			subdiv_q  <= ccsi_pkg::SUBDIV_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				ccsi_pkg::REG_TENSION: tension_q <= cfg_data;
				ccsi_pkg::REG_SUBDIV:  subdiv_q  <= ccsi_pkg::SUB_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ph_q          <= '0;
			count_q       <= '0;
			k_q           <= SK_RUN;
			k_end_q       <= SK_RUN;
			i_q           <= '0;
			curve_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				curve_valid_q <= 1'b1;
			end else if (!curve_stall) begin
				curve_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q     <= k_start;
						k_end_q <= k_stop;
						i_q     <= '0;
						if (is_last) begin
							count_q <= '0;
							state_q <= ST_SEG;
						end else begin
							count_q <= count_q + CW'(1);
							if (idx_w >= IW'(3)) begin
								state_q <= ST_SEG;
							end
						end
					end
				end
				ST_SEG: begin
					i_q     <= '0;
					ph_q    <= '0;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (ph_q == PH_PREP_END) begin
						ph_q    <= '0;
						state_q <= ST_EMIT;
					end else begin
						ph_q <= ph_q + 4'd1;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (seg_done) begin
							if (k_q == k_end_q) begin
								state_q <= ST_IDLE;
							end else begin
								k_q     <= k_q + 3'd1;
								state_q <= ST_SEG;
							end
						end else begin
							i_q     <= i_q + SIW'(1);
							ph_q    <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (ph_q == PH_MUL_END) begin
						state_q <= ST_WAIT;
					end else begin
						ph_q <= ph_q + 4'd1;
					end
				end
				ST_WAIT: begin
					if (msts.res_valid && msts.res_y) begin
						state_q <= ST_EMIT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Point history and segment operands; all written before they are read.
	always_ff @(posedge clk) begin
		if (accept) begin
			old0_q <= r0_q;
			r0_q   <= r1_q;
			r1_q   <= r2_q;
			r2_q   <= cur;
			base_q <= count_q;
			s_m1_q <= SIW'(s_eff - ccsi_pkg::SUB_W'(1));
			if (idx_w == IW'(0)) begin
				f0_q <= cur;
			end
			if (idx_w == IW'(1)) begin
				f1_q <= cur;
			end
			if (idx_w == IW'(2)) begin
				th_q <= cur;
			end
		end
		if (state_q == ST_SEG) begin
			seg_a_q  <= sel_a;
			seg_b_q  <= sel_b;
			seg_c_q  <= sel_c;
			seg_d_q  <= sel_d;
			segidx_q <= sel_idx;
		end
		if (msts.m_valid) begin
			m_q[msts.mdst] <= msts.m;
		end
		if (msts.res_valid) begin
			if (msts.res_y) begin
				ry_q <= msts.res;
			end else begin
				rx_q <= msts.res;
			end
		end
		w_q <= basis_w[s_m1_q][i_q];
		if (out_load) begin
			curve_q.curve_x       <= (i_q == '0) ? seg_b_q.x : rx_q;
			curve_q.curve_y       <= (i_q == '0) ? seg_b_q.y : ry_q;
			curve_q.segment_index <= segidx_q;
			curve_q.step_index    <= ccsi_pkg::STEP_W'(i_q);
			curve_q.last_result   <= seg_done && (k_q == k_end_q);
		end
	end

	assign curve_valid = curve_valid_q;
	assign curve       = curve_q;

	`CCSI_CHECK_NOW(a_y_done_in_wait, msts.res_valid && msts.res_y, state_q == ST_WAIT, "y result outside wait")
	`CCSI_CHECK_NOW(a_step_in_range, state_q != ST_IDLE, i_q <= s_m1_q, "step beyond segment length")
	`CCSI_CHECK_NOW(a_kind_in_range, state_q != ST_IDLE, k_q <= k_end_q, "segment kind beyond run end")
	`CCSI_CHECK_NEXT(a_load_shows, out_load, curve_valid, "loaded result not presented")

endmodule

### hdl/ccsi_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsi_mac
// Shared multiplier with accumulator, rounding and saturation, three stages.
// ----------------------------------------------------------------------------
module ccsi_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [ccsi_pkg::WGT_W-1:0]   op_a,
	input  logic signed [ccsi_pkg::MOP_W-1:0]   op_b,
	input  ccsi_pkg::mac_ctl_t                  ctl,
	output ccsi_pkg::mac_sts_t                  sts
);

	ccsi_pkg::mac_ctl_t                      ctl_s1;
	logic signed [ccsi_pkg::PROD_W-1:0]      mul_s1;
	logic signed [ccsi_pkg::ACC_W-1:0]       acc_q;
	logic signed [ccsi_pkg::ACC_W-1:0]       term;
	logic signed [ccsi_pkg::ACC_W-1:0]       rnd;
	logic signed [ccsi_pkg::ACC_W-ccsi_pkg::ROUND_SHIFT-1:0] shr;
	logic                                    fin_s2;
	logic                                    y_s2;
	logic                                    res_valid_s3;
	logic                                    res_y_s3;
	logic signed [ccsi_pkg::COORD_W-1:0]     res_s3;
	logic signed [ccsi_pkg::COORD_W-1:0]     sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		mul_s1 <= op_a * op_b;
	end

	always_comb begin
		term = ctl_s1.shift ? (ccsi_pkg::ACC_W'(mul_s1) <<< ccsi_pkg::PROD_SHIFT)
			: ccsi_pkg::ACC_W'(mul_s1);
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid && !ctl_s1.mwrite) begin
			acc_q <= (ctl_s1.clear ? '0 : acc_q) + term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s2       <= 1'b0;
			y_s2         <= 1'b0;
			res_valid_s3 <= 1'b0;
			res_y_s3     <= 1'b0;
		end else begin
			fin_s2       <= ctl_s1.valid && !ctl_s1.mwrite && ctl_s1.fin;
			y_s2         <= ctl_s1.coord_y;
			res_valid_s3 <= fin_s2;
			res_y_s3     <= y_s2;
		end
	end

	// Round half up at 2^-31 of the sum, then clamp to the coordinate range.
	always_comb begin
		rnd = acc_q + (ccsi_pkg::ACC_W'(1) <<< (ccsi_pkg::ROUND_SHIFT - 1));
		shr = (ccsi_pkg::ACC_W-ccsi_pkg::ROUND_SHIFT)'(rnd >>> ccsi_pkg::ROUND_SHIFT);
		if (shr > (ccsi_pkg::ACC_W-ccsi_pkg::ROUND_SHIFT)'(32767)) begin
			sat = 16'sh7FFF;
		end else if (shr < -(ccsi_pkg::ACC_W-ccsi_pkg::ROUND_SHIFT)'(32768)) begin
			sat = 16'sh8000;
		end else begin
			sat = ccsi_pkg::COORD_W'(shr);
		end
	end

	always_ff @(posedge clk) begin
		if (fin_s2) begin
			res_s3 <= sat;
		end
	end

	always_comb begin
		sts.m_valid   = ctl_s1.valid && ctl_s1.mwrite;
		sts.mdst      = ctl_s1.mdst;
		sts.m         = ccsi_pkg::MOP_W'(mul_s1);
		sts.res_valid = res_valid_s3;
		sts.res_y     = res_y_s3;
		sts.res       = res_s3;
	end

endmodule

### sim/closed_cardinal_spline_interpolator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closed_cardinal_spline_interpolator_core_tb
// Self-checking bench for the closed cardinal spline interpolator core.
// ----------------------------------------------------------------------------
// Control points are sent as closed curves of various lengths. A behavioural
// copy of the spline arithmetic predicts every curve point, and each item
// leaving the core is compared field by field with the oldest prediction.
// Tension and subdivisions are changed between curves while the core is idle,
// and both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module closed_cardinal_spline_interpolator_core_tb;

	localparam int  NPTS_MAX    = 2048;
	localparam int  SUBDIV_MAX  = 16;
	localparam int  SETTLE      = 60;
	localparam longint CYCLE_LIMIT = 3000000;

	logic                            clk;
	logic                            arst_n;
	logic                            point_valid;
	logic                            point_stall;
	ccsi_pkg::point_t                point;
	logic                            curve_valid;
	logic                            curve_stall = 1'b0;
	ccsi_pkg::curve_t                curve;
	logic                            cfg_write;
	logic [ccsi_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ccsi_pkg::CFG_DATA_W-1:0] cfg_data;

	// Shadow of the core's state, kept in step with every accepted item.
	logic signed [15:0]         tension_q;
	logic [ccsi_pkg::SUB_W-1:0] subdiv_q;
	int                         held_count;
	ccsi_pkg::xy_t              first_pt [2];
	ccsi_pkg::xy_t              third_pt;
	ccsi_pkg::xy_t              recent_pt [3];

	ccsi_pkg::curve_t curve_due [$];
	int     error_count = 0;
	longint cycle_count = 0;
	bit     quiet;
	int     stall_left = 0;
	int     items_sent;

	closed_cardinal_spline_interpolator_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point      (point),
		.curve_valid(curve_valid),
		.curve_stall(curve_stall),
		.curve      (curve),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Most gaps are short; a few are long enough to drain or fill the core.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Hermite weight in Q1.16, rounded half away from zero.
	function automatic longint weight_q16(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (2 * mag * 65536 + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	// One blended coordinate at step i of s, saturated to 16 bits.
	function automatic logic signed [15:0] hermite_coord(longint a, longint b,
			longint c, longint d, longint i, longint s);
		longint s3, h00, h10, h01, h11, m1, m2, acc, r, tfq;
		tfq = 16384 - longint'(tension_q);
		s3 = s * s * s;
		h00 = weight_q16(2*i*i*i - 3*i*i*s + s3, s3);
		h10 = weight_q16(i*i*i - 2*i*i*s + i*s*s, s3);
		h01 = weight_q16(-2*i*i*i + 3*i*i*s, s3);
		h11 = weight_q16(i*i*i - i*i*s, s3);
		m1 = tfq * (c - a);
		m2 = tfq * (d - b);
		acc = (h00 * b + h01 * c) * 32768 + h10 * m1 + h11 * m2;
		r = (acc + (longint'(1) << 30)) >>> 31;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	// Queue the points of segment seg running from b towards c.
	task automatic queue_segment(ccsi_pkg::xy_t a, ccsi_pkg::xy_t b, ccsi_pkg::xy_t c,
			ccsi_pkg::xy_t d, int seg, int s);
		ccsi_pkg::curve_t res;
		for (int i = 0; i < s; i++) begin
			res = '0;
			res.curve_x = b.x;
			res.curve_y = b.y;
			if (i != 0) begin
				res.curve_x = hermite_coord(a.x, b.x, c.x, d.x, i, s);
				res.curve_y = hermite_coord(a.y, b.y, c.y, d.y, i, s);
			end
			res.segment_index = seg[ccsi_pkg::SEG_W-1:0];
			res.step_index = i[ccsi_pkg::STEP_W-1:0];
			curve_due.push_back(res);
		end
	endtask

	task automatic shift_recent(ccsi_pkg::xy_t p);
		recent_pt[0] = recent_pt[1];
		recent_pt[1] = recent_pt[2];
		recent_pt[2] = p;
	endtask

	// Work out every curve point that one accepted control point causes.
	task automatic predict_curve(ccsi_pkg::point_t p);
		ccsi_pkg::xy_t cur;
		int  idx, s, nn, before_n;
		bit  closing;
		cur.x = p.point_x;
		cur.y = p.point_y;
		idx = held_count;
		closing = p.last_point || idx >= NPTS_MAX - 1;
		s = subdiv_q;
		if (s < 1)
			s = 1;
		if (s > SUBDIV_MAX)
			s = SUBDIV_MAX;
		before_n = curve_due.size();
		if (idx == 0)
			first_pt[0] = cur;
		else if (idx == 1)
			first_pt[1] = cur;
		else if (idx == 2)
			third_pt = cur;
		if (!closing) begin
			if (idx >= 3)
				queue_segment(recent_pt[0], recent_pt[1], recent_pt[2], cur, idx - 2, s);
			shift_recent(cur);
			held_count = idx + 1;
		end else begin
			nn = idx + 1;
			if (nn == 1) begin
				queue_segment(cur, cur, cur, cur, 0, 1);
			end else if (nn == 2) begin
				queue_segment(first_pt[1], first_pt[0], first_pt[1], first_pt[0], 0, s);
				queue_segment(first_pt[0], first_pt[1], first_pt[0], first_pt[1], 1, s);
			end else begin
				if (nn >= 4) begin
					// Four segments close together, so the count is capped.
					if (4 * s > ccsi_pkg::RESULT_LIMIT)
						s = ccsi_pkg::RESULT_LIMIT / 4;
					queue_segment(recent_pt[0], recent_pt[1], recent_pt[2], cur, nn - 3, s);
				end
				shift_recent(cur);
				queue_segment(recent_pt[0], recent_pt[1], recent_pt[2], first_pt[0],
					nn - 2, s);
				queue_segment(recent_pt[1], recent_pt[2], first_pt[0], first_pt[1],
					nn - 1, s);
				queue_segment(recent_pt[2], first_pt[0], first_pt[1], third_pt, 0, s);
			end
			held_count = 0;
		end
		if (curve_due.size() > before_n)
			curve_due[$].last_result = 1'b1;
	endtask

	// Offer one control point and wait until the core takes it.
	task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
		ccsi_pkg::point_t p;
		int     gap;
		p.point_x = x;
		p.point_y = y;
		p.last_point = last;
		point_valid <= 1'b1;
		point <= p;
		do
			@(posedge clk);
		while (point_stall);
		predict_curve(p);
		items_sent++;
		gap = gap_len();
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Let the core drain fully, including work on items that give no result.
	task automatic wait_idle();
		point_valid <= 1'b0;
		@(posedge clk);
		while (curve_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [ccsi_pkg::CFG_IDX_W-1:0] idx,
			logic [ccsi_pkg::CFG_DATA_W-1:0] val);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == ccsi_pkg::REG_TENSION)
			tension_q = val;
		else
			subdiv_q = val[ccsi_pkg::SUB_W-1:0];
	endtask

	function automatic logic signed [15:0] rand_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		if (r < 4)
			return 16'($urandom());
		return $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
	endfunction

	task automatic send_curve(int n);
		for (int k = 0; k < n; k++)
			send_point(rand_coord(), rand_coord(), k == n - 1);
	endtask

	// Degenerate curves: one, two and three points, with extreme coordinates.
	task automatic test_short_curves();
		write_reg(ccsi_pkg::REG_SUBDIV, 16'd4);
		send_point(16'sh7fff, 16'sh8000, 1'b1);
		send_point(16'sh8000, 16'sh7fff, 1'b0);
		send_point(16'sh7fff, 16'sh8000, 1'b1);
		send_point(16'sh0000, 16'sh7fff, 1'b0);
		send_point(16'sh8000, 16'sh0000, 1'b0);
		send_point(16'sh7fff, 16'sh7fff, 1'b1);
	endtask

	// Tension and subdivision extremes, including out-of-range subdivisions
	// that the core clamps and the cap on the closing segments.
	task automatic test_register_extremes();
		write_reg(ccsi_pkg::REG_TENSION, 16'h8000);
		write_reg(ccsi_pkg::REG_SUBDIV, 16'd16);
		send_point(16'sh7fff, 16'sh7fff, 1'b0);
		send_point(16'sh8000, 16'sh8000, 1'b0);
		send_point(16'sh7fff, 16'sh8000, 1'b0);
		send_point(16'sh8000, 16'sh7fff, 1'b0);
		send_point(16'sh0100, 16'shff00, 1'b1);
		write_reg(ccsi_pkg::REG_TENSION, 16'h7fff);
		write_reg(ccsi_pkg::REG_SUBDIV, 16'd0);
		send_curve(5);
		write_reg(ccsi_pkg::REG_TENSION, 16'h4000);
		write_reg(ccsi_pkg::REG_SUBDIV, 16'd31);
		send_curve(4);
		write_reg(ccsi_pkg::REG_TENSION, 16'hc000);
		write_reg(ccsi_pkg::REG_SUBDIV, 16'd1);
		send_curve(4);
	endtask

	task automatic test_random_curves();
		int start;
		start = items_sent;
		while (items_sent - start < 85) begin
			if ($urandom_range(0, 3) == 0)
				write_reg(ccsi_pkg::REG_TENSION, 16'($urandom()));
			if ($urandom_range(0, 3) == 0)
				write_reg(ccsi_pkg::REG_SUBDIV, 16'($urandom_range(0, 31)));
			quiet = ($urandom_range(0, 5) == 0);
			send_curve($urandom_range(0, 4) == 0 ? $urandom_range(1, 3) :
				$urandom_range(4, 12));
		end
		quiet = 1'b0;
	endtask

	// Each curve point leaving the core is checked against the oldest
	// prediction; the stall for the next cycle is chosen afterwards.
	always @(posedge clk) begin
		if (arst_n && curve_valid && !curve_stall) begin
			if (curve_due.size() == 0) begin
				$error("curve point with nothing expected: %p", curve);
				error_count++;
			end else begin
				ccsi_pkg::curve_t exp_pt;
				exp_pt = curve_due.pop_front();
				if (curve.curve_x !== exp_pt.curve_x) begin
					$error("curve_x expected %0d got %0d", exp_pt.curve_x, curve.curve_x);
					error_count++;
				end
				if (curve.curve_y !== exp_pt.curve_y) begin
					$error("curve_y expected %0d got %0d", exp_pt.curve_y, curve.curve_y);
					error_count++;
				end
				if (curve.segment_index !== exp_pt.segment_index) begin
					$error("segment_index expected %0d got %0d",
						exp_pt.segment_index, curve.segment_index);
					error_count++;
				end
				if (curve.step_index !== exp_pt.step_index) begin
					$error("step_index expected %0d got %0d",
						exp_pt.step_index, curve.step_index);
					error_count++;
				end
				if (curve.last_result !== exp_pt.last_result) begin
					$error("last_result expected %0d got %0d",
						exp_pt.last_result, curve.last_result);
					error_count++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			curve_stall <= 1'b1;
		end else begin
			int g;
			g = gap_len();
			stall_left <= (g > 0) ? g - 1 : 0;
			curve_stall <= (g > 0);
		end
	end

	// Safety net against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		point_valid = 1'b0;
		point = '0;
		cfg_write = 1'b0;
		cfg_index = ccsi_pkg::REG_TENSION;
		cfg_data = '0;
		tension_q = 16'sd0;
		subdiv_q = ccsi_pkg::SUBDIV_RESET;
		held_count = 0;
		quiet = 1'b0;
		items_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// The reset settings are used first, before any write.
		send_curve(5);
		test_short_curves();
		test_register_extremes();
		test_random_curves();
		wait_idle();

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/ccsi_pkg.sv
hdl/ccsi_mac.sv
hdl/closed_cardinal_spline_interpolator_core.sv
sim/closed_cardinal_spline_interpolator_core_tb.sv
